/* rtl/core/qps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature position and speed: shared definitions
// Widths, command codes, beat types and phase stepping for the x4 decoder.
// ----------------------------------------------------------------------------
package qps_pkg;

  // Width of the internal position count (valid range 16 to 48).
  localparam int POS_WIDTH = 32;

  // Speed scaling: change * (60 * 100) / 64, truncated toward zero.
  localparam int SPEED_NUM   = 60 * 100;
  localparam int SPEED_DEN   = 64;
  localparam int SPEED_SHIFT = $clog2(SPEED_DEN);

  // Signed width that holds the scale numerator.
  localparam int NUM_W   = $clog2(SPEED_NUM) + 1;
  localparam int PROD_W  = POS_WIDTH + NUM_W;
  // Working width for saturation, always wider than the 32-bit result.
  localparam int SCALE_W = (PROD_W > 34) ? PROD_W : 34;

  localparam logic signed [NUM_W-1:0] SPEED_NUM_S = NUM_W'(SPEED_NUM);
  localparam logic signed [31:0]      SPEED_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]      SPEED_MIN   = 32'sh8000_0000;

  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [1:0]           phase_t;

  // Phase after reset: A high, B low.
  localparam phase_t PHASE_RESET = 2'b10;

  // Command codes of an input beat.
  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_TICK   = 2'd2
  } func_t;

  typedef struct packed {
    func_t              func;
    logic               enc_a;
    logic               enc_b;
    logic signed [31:0] new_position;
    logic               forward;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] speed;
  } out_beat_t;

  // Next phase along the forward sequence 10, 00, 01, 11.
  function automatic phase_t step_fwd(input phase_t ph);
    phase_t nx;
    case (ph)
      2'b00:   nx = 2'b01;
      2'b01:   nx = 2'b11;
      2'b10:   nx = 2'b00;
      default: nx = 2'b10;
    endcase
    return nx;
  endfunction

  // Next phase along the reverse sequence.
  function automatic phase_t step_rev(input phase_t ph);
    phase_t nx;
    case (ph)
      2'b00:   nx = 2'b10;
      2'b01:   nx = 2'b00;
      2'b10:   nx = 2'b11;
      default: nx = 2'b01;
    endcase
    return nx;
  endfunction

endpackage

/* rtl/core/qps_speed_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature speed scaling
// Turns the count change between two ticks into a saturated 32-bit speed.
// ----------------------------------------------------------------------------
module qps_speed_scale (
  input  qps_pkg::pos_t      cnt,
  input  qps_pkg::pos_t      last_tick,
  input  logic               forward,
  output logic signed [31:0] speed
);

  localparam logic signed [qps_pkg::SCALE_W-1:0] LIM_MAX =
    qps_pkg::SCALE_W'(qps_pkg::SPEED_MAX);
  localparam logic signed [qps_pkg::SCALE_W-1:0] LIM_MIN =
    qps_pkg::SCALE_W'(qps_pkg::SPEED_MIN);

  qps_pkg::pos_t                      diff;
  logic signed [qps_pkg::PROD_W-1:0]  prod;
  logic signed [qps_pkg::PROD_W-1:0]  biased;
  logic signed [qps_pkg::PROD_W-1:0]  quot;
  logic signed [qps_pkg::SCALE_W-1:0] quot_w;

  // Change since the last tick, oriented by direction; wraps at the count width.
  assign diff = forward ? (cnt - last_tick) : (last_tick - cnt);

  // Constant multiply, then divide by a power of two rounding toward zero.
  assign prod   = qps_pkg::PROD_W'($signed(diff)) *
                  qps_pkg::PROD_W'(qps_pkg::SPEED_NUM_S);
  assign biased = prod + (prod[qps_pkg::PROD_W-1] ?
                          qps_pkg::PROD_W'(qps_pkg::SPEED_DEN - 1) :
                          qps_pkg::PROD_W'(0));
  assign quot   = biased >>> qps_pkg::SPEED_SHIFT;
  assign quot_w = qps_pkg::SCALE_W'(quot);

  // Clamp to the 32-bit signed range.
  always_comb begin
    if (quot_w > LIM_MAX) begin
      speed = qps_pkg::SPEED_MAX;
    end else if (quot_w < LIM_MIN) begin
      speed = qps_pkg::SPEED_MIN;
    end else begin
      speed = quot_w[31:0];
    end
  end

endmodule

/* rtl/core/quadrature_position_speed.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature position and speed decoder
// x4 quadrature decoding with position load and scaled speed measurement.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one command per
//   beat: a pin sample of channels A and B, a position load, or a speed tick.
//   Every input beat yields exactly one result beat on the output channel
//   (out_valid, out_stall, out_data) holding the position after that command
//   and the speed from the latest tick.
//   An accepted beat is captured in the input register, then goes through the
//   decode, scale and saturate logic into the result register once that
//   register can take it. Throughput is one beat per cycle while out_stall
//   does not hold the result register full, set by the single pass of that
//   logic, which also updates the phase, count and speed state.
//   A new beat is taken while a finished result still waits in the result
//   register; when out_stall holds the result register full, one more beat
//   fills the input register, and from then on in_stall follows out_stall.
//   Synchronous reset clears the valid flags of both pipeline registers, sets
//   the phase to A high and B low, and zeroes the position, the tick snapshot and the speed.
// ----------------------------------------------------------------------------
module quadrature_position_speed (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qps_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qps_pkg::out_beat_t  out_data
);

  logic                s1_valid_r;
  qps_pkg::in_beat_t   s1_data_r;
  logic                out_valid_r;
  qps_pkg::out_beat_t  out_data_r;

  qps_pkg::phase_t     phase_r;
  qps_pkg::phase_t     phase_nxt;
  qps_pkg::pos_t       cnt_r;
  qps_pkg::pos_t       cnt_nxt;
  qps_pkg::pos_t       tick_r;
  qps_pkg::pos_t       tick_nxt;
  logic signed [31:0]  speed_r;
  logic signed [31:0]  speed_nxt;

  logic                adv;
  logic                fire;
  logic [1:0]          pins;
  logic signed [63:0]  load_ext;
  logic [63:0]         cnt_ext;
  logic signed [31:0]  tick_speed;

  // Handshake: the result register can take a beat when empty or draining.
  assign adv       = ~out_valid_r | ~out_stall;
  assign fire      = s1_valid_r & adv;
  assign in_stall  = s1_valid_r & ~adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // Speed from the change since the previous tick.
  qps_speed_scale u_scale (
    .cnt       (cnt_r),
    .last_tick (tick_r),
    .forward   (s1_data_r.forward),
    .speed     (tick_speed)
  );

  assign pins     = {s1_data_r.enc_a, s1_data_r.enc_b};
  assign load_ext = 64'($signed(s1_data_r.new_position));

  // Command decode and next state.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    tick_nxt  = tick_r;
    speed_nxt = speed_r;
    case (s1_data_r.func)
      qps_pkg::FUNC_SAMPLE: begin
        if (pins == qps_pkg::step_fwd(phase_r)) begin
          phase_nxt = pins;
          cnt_nxt   = cnt_r + qps_pkg::pos_t'(1);
        end else if (pins == qps_pkg::step_rev(phase_r)) begin
          phase_nxt = pins;
          cnt_nxt   = cnt_r - qps_pkg::pos_t'(1);
        end
      end
      qps_pkg::FUNC_LOAD: begin
        cnt_nxt = load_ext[qps_pkg::POS_WIDTH-1:0];
      end
      qps_pkg::FUNC_TICK: begin
        speed_nxt = tick_speed;
        tick_nxt  = cnt_r;
      end
      default: begin
        // Unused command: state holds, the result reports it as is.
      end
    endcase
  end

  // The reported position is the low 32 bits of the count.
  assign cnt_ext = 64'(cnt_nxt);

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= qps_pkg::PHASE_RESET;
      cnt_r   <= '0;
      tick_r  <= '0;
      speed_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      tick_r  <= tick_nxt;
      speed_r <= speed_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.position <= cnt_ext[31:0];
      out_data_r.speed    <= speed_nxt;
    end
  end

  // A beat that leaves the input register shows up as a result next cycle.
  a_fire_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed beat did not reach the result register");

  // The input side is only held back while the input register is occupied.
  a_stall_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a held beat");

  // The phase moves only on a pin sample.
  a_phase_on_sample : assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && (s1_data_r.func == qps_pkg::FUNC_SAMPLE)) |=> $stable(phase_r))
    else $error("phase changed without a pin sample");

  // Speed and tick snapshot change only on a speed tick.
  a_speed_on_tick : assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && (s1_data_r.func == qps_pkg::FUNC_TICK)) |=>
      ($stable(speed_r) && $stable(tick_r)))
    else $error("speed state changed without a tick");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature position and speed decoder: self-checking testbench
// Directed pin, load, speed and unused-command cases, then random command
// traffic with random idling on both channels and one long output hold-off.
// A predictor of the decoder state checks every result beat field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 330;
  localparam int BURST_ITEMS  = 40;
  localparam int FILL_ITEMS   = 30;

  // Command code outside the decoded set; the block must leave its state alone.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Speed scaling and the 32-bit clamp limits.
  localparam longint RPM_MUL     = 6000;
  localparam longint RPM_DIV     = 64;
  localparam longint SPEED_CEIL  = 64'sd2147483647;
  localparam longint SPEED_FLOOR = -64'sd2147483648;

  localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  qps_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_stall;
  qps_pkg::out_beat_t out_data;

  // Stimulus controls shared between the test tasks and the receiver.
  bit              idle_on;
  bit              stall_on;
  bit              hold_request;
  qps_pkg::phase_t stim_phase;

  // Predicted decoder state and the results still owed by the block.
  qps_pkg::phase_t    track_phase;
  qps_pkg::pos_t      track_count;
  qps_pkg::pos_t      tick_snapshot;
  logic signed [31:0] held_speed;
  qps_pkg::out_beat_t expected_results[$];

  int errors;
  int cycle_count;
  int n_samples;
  int n_steps_fwd;
  int n_steps_rev;
  int n_loads;
  int n_ticks;
  int n_clamped;
  int n_unused;

  quadrature_position_speed i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Position of a pin pattern along the forward sequence 10, 00, 01, 11.
  function automatic logic [1:0] gray_index(input qps_pkg::phase_t pins);
    return {pins[0], ~(pins[1] ^ pins[0])};
  endfunction

  // Pin pattern at a given position of the forward sequence.
  function automatic qps_pkg::phase_t pins_at(input logic [1:0] idx);
    return {~idx[0] ^ idx[1], idx[1]};
  endfunction

  // Applies one accepted command to the tracked state and returns its result.
  function automatic qps_pkg::out_beat_t decode_and_measure(input qps_pkg::in_beat_t beat);
    qps_pkg::phase_t                      pins;
    logic [1:0]                           here;
    logic [1:0]                           there;
    qps_pkg::pos_t                        diff;
    logic signed [qps_pkg::POS_WIDTH-1:0] delta;
    longint                               scaled;
    qps_pkg::out_beat_t                   res;
    case (beat.func)
      qps_pkg::FUNC_SAMPLE: begin
        n_samples++;
        pins  = {beat.enc_a, beat.enc_b};
        here  = gray_index(track_phase);
        there = gray_index(pins);
        if (there == 2'(here + 2'd1)) begin
          track_phase = pins;
          track_count = track_count + qps_pkg::pos_t'(1);
          n_steps_fwd++;
        end else if (there == 2'(here - 2'd1)) begin
          track_phase = pins;
          track_count = track_count - qps_pkg::pos_t'(1);
          n_steps_rev++;
        end
      end
      qps_pkg::FUNC_LOAD: begin
        n_loads++;
        track_count = qps_pkg::pos_t'(beat.new_position);
      end
      qps_pkg::FUNC_TICK: begin
        n_ticks++;
        diff   = beat.forward ? track_count - tick_snapshot : tick_snapshot - track_count;
        delta  = diff;
        scaled = (longint'(delta) * RPM_MUL) / RPM_DIV;
        if (scaled > SPEED_CEIL) begin
          scaled = SPEED_CEIL;
          n_clamped++;
        end else if (scaled < SPEED_FLOOR) begin
          scaled = SPEED_FLOOR;
          n_clamped++;
        end
        held_speed    = 32'(scaled);
        tick_snapshot = track_count;
      end
      default: begin
        n_unused++;
      end
    endcase
    res.position = 32'(track_count);
    res.speed    = held_speed;
    return res;
  endfunction

  // Predict on every accepted input beat and check every accepted result beat.
  always @(posedge clk) begin : track_results
    qps_pkg::out_beat_t want;
    if (!rst_n) begin
      track_phase   = qps_pkg::PHASE_RESET;
      track_count   = '0;
      tick_snapshot = '0;
      held_speed    = '0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(decode_and_measure(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, position %0d speed %0d",
                   $time, out_data.position, out_data.speed);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.position !== want.position) begin
            $display("%0t: position mismatch, expected %0d, actual %0d",
                     $time, want.position, out_data.position);
            errors++;
          end
          if (out_data.speed !== want.speed) begin
            $display("%0t: speed mismatch, expected %0d, actual %0d",
                     $time, want.speed, out_data.speed);
            errors++;
          end
        end
      end
    end
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("quadrature_position_speed verification failed");
      $finish;
    end
  end

  // Receiver: random stall runs, a long hold-off on request, or none at all.
  initial begin : receiver
    int stall_left;
    int free_left;
    int hold_left;
    int pick;
    stall_left = 0;
    free_left  = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!stall_on) begin
        out_stall <= 1'b0;
      end else begin
        if (stall_left == 0 && free_left == 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 55) free_left = $urandom_range(1, 8);
          else if (pick < 88) stall_left = $urandom_range(1, 3);
          else stall_left = $urandom_range(10, 40);
        end
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          free_left--;
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Offers one beat, waits until it is taken, then may idle for a random gap.
  task automatic send_beat(input qps_pkg::in_beat_t beat);
    int              gap;
    int              pick;
    qps_pkg::phase_t pins;
    logic [1:0]      here;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Mirror the phase so that random samples can follow the encoder sequence.
    if (beat.func == qps_pkg::FUNC_SAMPLE) begin
      pins = {beat.enc_a, beat.enc_b};
      here = gray_index(stim_phase);
      if (gray_index(pins) == 2'(here + 2'd1) || gray_index(pins) == 2'(here - 2'd1)) begin
        stim_phase = pins;
      end
    end
    gap = 0;
    if (idle_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) gap = $urandom_range(10, 40);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A sample beat with random pin, position and direction fields; callers set the fields that matter.
  function automatic qps_pkg::in_beat_t filler_beat();
    qps_pkg::in_beat_t beat;
    beat.func         = qps_pkg::FUNC_SAMPLE;
    beat.enc_a        = 1'($urandom_range(0, 1));
    beat.enc_b        = 1'($urandom_range(0, 1));
    beat.new_position = $urandom;
    beat.forward      = 1'($urandom_range(0, 1));
    return beat;
  endfunction

  task automatic send_sample(input logic a, input logic b);
    qps_pkg::in_beat_t beat;
    beat       = filler_beat();
    beat.func  = qps_pkg::FUNC_SAMPLE;
    beat.enc_a = a;
    beat.enc_b = b;
    send_beat(beat);
  endtask

  task automatic send_load(input logic signed [31:0] value);
    qps_pkg::in_beat_t beat;
    beat              = filler_beat();
    beat.func         = qps_pkg::FUNC_LOAD;
    beat.new_position = value;
    send_beat(beat);
  endtask

  task automatic send_tick(input logic fwd);
    qps_pkg::in_beat_t beat;
    beat         = filler_beat();
    beat.func    = qps_pkg::FUNC_TICK;
    beat.forward = fwd;
    send_beat(beat);
  endtask

  // Mostly legal encoder steps with some jumps, loads, ticks and unused codes.
  function automatic qps_pkg::in_beat_t random_command();
    qps_pkg::in_beat_t beat;
    int                pick;
    logic [1:0]        here;
    qps_pkg::phase_t   pins;
    beat = filler_beat();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      here = gray_index(stim_phase);
      if (pick < 32) pins = pins_at(2'(here + 2'd1));
      else if (pick < 56) pins = pins_at(2'(here - 2'd1));
      else pins = qps_pkg::phase_t'($urandom_range(0, 3));
      beat.func  = qps_pkg::FUNC_SAMPLE;
      beat.enc_a = pins[1];
      beat.enc_b = pins[0];
    end else if (pick < 78) begin
      beat.func = qps_pkg::FUNC_LOAD;
      case ($urandom_range(0, 3))
        0: beat.new_position = POS_MAX - $signed(32'($urandom_range(0, 3)));
        1: beat.new_position = POS_MIN + $signed(32'($urandom_range(0, 3)));
        2: beat.new_position = $signed(32'($urandom_range(0, 8))) - 32'sd4;
        default: beat.new_position = $urandom;
      endcase
    end else if (pick < 97) begin
      beat.func = qps_pkg::FUNC_TICK;
    end else begin
      beat.func = qps_pkg::func_t'(FUNC_UNUSED);
    end
    return beat;
  endfunction

  // A full forward cycle, reverse steps, a held pattern, a skipped phase, small speeds.
  task automatic test_pin_decoding();
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    send_tick(1'b1);
    send_sample(1'b0, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Count wrap at both ends, clamped speed both ways, change across the wrap,
  // and a change equal to the most negative value taken in reverse.
  task automatic test_load_and_speed_limits();
    send_load(POS_MAX);
    send_sample(1'b1, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_load(POS_MIN);
    send_sample(1'b0, 1'b1);
    send_tick(1'b0);
    send_load(32'sd0);
    send_tick(1'b1);
    send_load(POS_MIN);
    send_tick(1'b0);
  endtask

  task automatic test_unused_command();
    qps_pkg::in_beat_t beat;
    beat      = filler_beat();
    beat.func = qps_pkg::func_t'(FUNC_UNUSED);
    send_beat(beat);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_beat(random_command());
  endtask

  // No gaps and no stalls on either side.
  task automatic test_back_to_back(input int count);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    repeat (count) send_beat(random_command());
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while beats keep coming.
  task automatic test_output_hold(input int count);
    idle_on      = 1'b0;
    hold_request = 1'b1;
    repeat (count) send_beat(random_command());
    idle_on      = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    idle_on      = 1'b1;
    stall_on     = 1'b1;
    hold_request = 1'b0;
    stim_phase   = qps_pkg::PHASE_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pin_decoding();
    test_load_and_speed_limits();
    test_unused_command();
    test_random_traffic(RANDOM_ITEMS);
    test_back_to_back(BURST_ITEMS);
    test_output_hold(FILL_ITEMS);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d pin samples (%0d forward, %0d reverse steps), %0d loads,",
             n_samples, n_steps_fwd, n_steps_rev, n_loads);
    $display("%0d speed ticks with %0d clamped, and %0d unused commands.",
             n_ticks, n_clamped, n_unused);
    if (errors == 0) begin
      $display("quadrature_position_speed verification clean");
    end else begin
      $display("quadrature_position_speed verification failed");
    end
    $finish;
  end

endmodule

/* quadrature_position_speed.f */
rtl/core/qps_pkg.sv
rtl/core/qps_speed_scale.sv
rtl/core/quadrature_position_speed.sv
verif/tb_top.sv
